### hw/rtl/i2c_master_status_sequencer_defines.svh
// assertion macros for the i2c master status sequencer checker
`ifndef I2C_MASTER_STATUS_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_STATUS_SEQUENCER_DEFINES_SVH

// property holds in the same cycle
`define I2CMS_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property holds in the following cycle
`define I2CMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/i2cms_pkg.sv
// types and constants shared by the i2c master status sequencer
package i2cms_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_STATUS = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_ACK      = 3'd2,
        CMD_NACK     = 3'd3,
        CMD_STOP     = 3'd4,
        CMD_STOP_CLR = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        OUT_IDLE = 2'd0,
        OUT_BUSY = 2'd1,
        OUT_OK   = 2'd2,
        OUT_FAIL = 2'd3
    } t_outcome;

    // bus status codes of the shift unit
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
    localparam logic [7:0] ST_SLAVE_FIRST  = 8'h60;
    localparam logic [7:0] ST_SLAVE_LAST   = 8'hC8;
    localparam logic [7:0] ST_NO_INFO      = 8'hF8;

    localparam logic [4:0] POS_MAX = 5'd31;

    typedef struct packed {
        t_func       func;
        logic [3:0]  buf_index;
        logic [7:0]  byte_value;
        logic [6:0]  slave_addr;
        logic        read_not_write;
        logic [4:0]  byte_count;
        logic        repeat_start;
        logic [7:0]  status_code;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        t_cmd        bus_command;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        t_outcome    transfer_status;
        logic        ready_res;
        logic [7:0]  read_byte;
        logic        refused;
    } t_result;

    typedef struct packed {
        logic        idle_flag;
        logic        repeat_pending;
        logic [4:0]  byte_pos;
        logic [6:0]  act_addr;
        logic        act_read;
        logic [4:0]  act_count;
        logic        act_repeat;
        t_outcome    outcome;
    } t_state;

    localparam t_state STATE_RESET = '{
        idle_flag:      1'b1,
        repeat_pending: 1'b0,
        byte_pos:       5'd0,
        act_addr:       7'd0,
        act_read:       1'b0,
        act_count:      5'd0,
        act_repeat:     1'b0,
        outcome:        OUT_IDLE
    };

    // buffer write request
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [7:0]  data;
    } t_buf_wr;

    // buffer read answer
    typedef struct packed {
        logic [7:0]  data;
        logic        ok;
    } t_rd;

endpackage

### hw/rtl/i2cms_if.sv
// item channels of the i2c master status sequencer
interface i2cms_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  buf_index;
    logic [7:0]  byte_value;
    logic [6:0]  slave_addr;
    logic        read_not_write;
    logic [4:0]  byte_count;
    logic        repeat_start;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;

    modport source (
        output valid, func, buf_index, byte_value, slave_addr, read_not_write,
               byte_count, repeat_start, status_code, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, func, buf_index, byte_value, slave_addr, read_not_write,
               byte_count, repeat_start, status_code, rx_byte,
        output ready
    );
endinterface

interface i2cms_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  bus_command;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  transfer_status;
    logic        ready_res;
    logic [7:0]  read_byte;
    logic        refused;

    modport source (
        output valid, bus_command, tx_valid, tx_byte, transfer_status, ready_res,
               read_byte, refused,
        input  ready
    );
    modport sink (
        input  valid, bus_command, tx_valid, tx_byte, transfer_status, ready_res,
               read_byte, refused,
        output ready
    );
endinterface

### hw/rtl/i2c_master_status_sequencer.sv
// top level of the i2c master status sequencer
//
// i_req carries one item per valid/ready handshake: a transmit byte load, a
// start action, a bus status code with its received byte, or a buffer read
// back. o_res carries exactly one result item for every accepted item, in
// order: the next bus command, an optional byte to shift out, the transfer
// outcome, the start-ready flag, a read-back byte and a refusal flag.
// an accepted item passes the input register, then the result register, before
// its result is shown
// throughput: one item per cycle unless o_res stalls; the decode of an item
// and the sequencer state update share a cycle, so the next item sees it
// the buffer is a memory with registered read; its address is formed at
// acceptance from the state that the item in flight leaves behind
// reset (i_rst_n low, synchronous) clears both stages and returns to idle
// with no transfer; buffer contents stay undefined until written
// when the receiver stalls the result register holds, one more item may wait
// in the input register, and i_req.ready then drops until o_res moves
module i2c_master_status_sequencer #(
    parameter int BUF_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cms_in_if.sink           i_req,
    i2cms_out_if.source        o_res
);
    import i2cms_pkg::*;

    // input stage
    logic     r_s1_valid;
    t_item    r_s1_item;
    t_item    in_item;
    logic     in_fire;
    logic     s1_fire;

    // sequencer state and decode
    t_state   r_state;
    t_state   n_state;
    t_result  s1_result;
    t_buf_wr  dec_wr;
    t_buf_wr  mem_wr;
    t_rd      rd;
    logic [4:0] rd_addr;

    // result stage
    logic     r_out_valid;
    t_result  r_out;

    assign in_item.func           = t_func'(i_req.func);
    assign in_item.buf_index      = i_req.buf_index;
    assign in_item.byte_value     = i_req.byte_value;
    assign in_item.slave_addr     = i_req.slave_addr;
    assign in_item.read_not_write = i_req.read_not_write;
    assign in_item.byte_count     = i_req.byte_count;
    assign in_item.repeat_start   = i_req.repeat_start;
    assign in_item.status_code    = i_req.status_code;
    assign in_item.rx_byte        = i_req.rx_byte;

    // the stage advances whenever the result register is free or draining
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_req.valid && i_req.ready;

    // read-back uses the item's index, a transmit uses the position that
    // will be current once this item reaches the decode
    always_comb begin
        if (in_item.func == FUNC_READ) begin
            rd_addr = {1'b0, in_item.buf_index};
        end else if (s1_fire) begin
            rd_addr = n_state.byte_pos;
        end else begin
            rd_addr = r_state.byte_pos;
        end
    end

    // buffer writes commit only when the decoding item retires
    always_comb begin
        mem_wr    = dec_wr;
        mem_wr.en = dec_wr.en && s1_fire;
    end

    i2cms_buffer #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_buffer (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .o_rd      (rd)
    );

    i2cms_decode u_decode (
        .i_item   (r_s1_item),
        .i_state  (r_state),
        .i_rd     (rd),
        .o_state  (n_state),
        .o_result (s1_result),
        .o_wr     (dec_wr)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= in_item;
        end
        if (s1_fire) begin
            r_out <= s1_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.bus_command     = r_out.bus_command;
    assign o_res.tx_valid        = r_out.tx_valid;
    assign o_res.tx_byte         = r_out.tx_byte;
    assign o_res.transfer_status = r_out.transfer_status;
    assign o_res.ready_res       = r_out.ready_res;
    assign o_res.read_byte       = r_out.read_byte;
    assign o_res.refused         = r_out.refused;
endmodule

### hw/rtl/i2cms_buffer.sv
// data buffer with registered read and write-to-read bypass
module i2cms_buffer #(
    parameter int BUF_DEPTH = 16
) (
    input  logic               i_clk,
    input  i2cms_pkg::t_buf_wr i_wr,
    input  logic               i_rd_en,
    input  logic [4:0]         i_rd_addr,
    output i2cms_pkg::t_rd     o_rd
);
    import i2cms_pkg::*;

    localparam int         AW      = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [8:0] DEPTH_W = 9'(BUF_DEPTH);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;
    logic       r_rd_ok;
    logic [8:0] wr_ext;
    logic [8:0] rd_ext;
    logic       wr_ok;
    logic       rd_ok;

    assign wr_ext = {4'b0, i_wr.addr};
    assign rd_ext = {4'b0, i_rd_addr};
    assign wr_ok  = wr_ext < DEPTH_W;
    assign rd_ok  = rd_ext < DEPTH_W;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_ok) begin
            r_mem[wr_ext[AW-1:0]] <= i_wr.data;
        end
    end

    // a write in the same cycle wins over the stored entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_ok <= rd_ok;
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_mem[rd_ext[AW-1:0]];
            end
        end
    end

    assign o_rd.data = r_rd_data;
    assign o_rd.ok   = r_rd_ok;
endmodule

### hw/rtl/i2cms_decode.sv
// per-item decode: next state, result and buffer write
module i2cms_decode (
    input  i2cms_pkg::t_item   i_item,
    input  i2cms_pkg::t_state  i_state,
    input  i2cms_pkg::t_rd     i_rd,
    output i2cms_pkg::t_state  o_state,
    output i2cms_pkg::t_result o_result,
    output i2cms_pkg::t_buf_wr o_wr
);
    import i2cms_pkg::*;

    t_state     n;
    t_result    res;
    t_buf_wr    wr;
    logic [4:0] pos_inc;
    logic [7:0] rd_val;
    logic       is_slave;

    assign pos_inc  = (i_state.byte_pos != POS_MAX) ? i_state.byte_pos + 5'd1
                                                    : i_state.byte_pos;
    assign rd_val   = i_rd.ok ? i_rd.data : 8'h00;
    assign is_slave = (i_item.status_code[2:0] == 3'b000)
                   && (i_item.status_code >= ST_SLAVE_FIRST)
                   && (i_item.status_code <= ST_SLAVE_LAST);

    always_comb begin
        n                   = i_state;
        res.bus_command     = CMD_NONE;
        res.tx_valid        = 1'b0;
        res.tx_byte         = 8'h00;
        res.read_byte       = 8'h00;
        res.refused         = 1'b0;
        wr.en               = 1'b0;
        wr.addr             = {1'b0, i_item.buf_index};
        wr.data             = i_item.byte_value;

        unique case (i_item.func)
            FUNC_LOAD: begin
                wr.en = 1'b1;
            end
            FUNC_START: begin
                if (i_state.idle_flag || i_state.repeat_pending) begin
                    n.act_addr       = i_item.slave_addr;
                    n.act_read       = i_item.read_not_write;
                    n.act_count      = i_item.byte_count;
                    n.act_repeat     = i_item.repeat_start;
                    n.idle_flag      = 1'b0;
                    n.repeat_pending = 1'b0;
                    n.byte_pos       = 5'd0;
                    n.outcome        = OUT_BUSY;
                    res.bus_command  = CMD_START;
                end else begin
                    res.refused = 1'b1;
                end
            end
            FUNC_STATUS: begin
                if (i_item.status_code != ST_NO_INFO) begin
                    unique case (i_item.status_code) inside
                        ST_START, ST_RESTART: begin
                            res.tx_valid    = 1'b1;
                            res.tx_byte     = {i_state.act_addr, i_state.act_read};
                            res.bus_command = CMD_NACK;
                        end
                        ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                            if (i_state.byte_pos < i_state.act_count) begin
                                res.tx_valid    = 1'b1;
                                res.tx_byte     = rd_val;
                                n.byte_pos      = pos_inc;
                                res.bus_command = CMD_NACK;
                            end else if (i_state.act_repeat) begin
                                n.repeat_pending = 1'b1;
                                res.bus_command  = CMD_START;
                            end else begin
                                n.outcome       = OUT_OK;
                                res.bus_command = CMD_STOP;
                            end
                        end
                        ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
                            n.outcome       = OUT_FAIL;
                            res.bus_command = CMD_STOP;
                        end
                        ST_ARB_LOST: begin
                            n.outcome       = OUT_FAIL;
                            res.bus_command = CMD_NACK;
                        end
                        ST_MR_SLA_ACK: begin
                            res.bus_command = CMD_ACK;
                        end
                        ST_MR_DATA_ACK: begin
                            wr.en           = 1'b1;
                            wr.addr         = i_state.byte_pos;
                            wr.data         = i_item.rx_byte;
                            n.byte_pos      = pos_inc;
                            res.bus_command = (pos_inc < i_state.act_count) ? CMD_ACK
                                                                            : CMD_NACK;
                        end
                        ST_MR_DATA_NACK: begin
                            if (i_state.act_repeat) begin
                                n.repeat_pending = 1'b1;
                                res.bus_command  = CMD_START;
                            end else begin
                                n.outcome       = OUT_OK;
                                res.bus_command = CMD_STOP;
                            end
                        end
                        ST_BUS_ERROR: begin
                            n.outcome       = OUT_FAIL;
                            res.bus_command = CMD_STOP_CLR;
                        end
                        default: begin
                            // slave codes are declined, anything else is ignored
                            if (is_slave) begin
                                res.bus_command = CMD_NACK;
                            end
                        end
                    endcase
                    n.idle_flag = (n.outcome != OUT_BUSY);
                end
            end
            FUNC_READ: begin
                res.read_byte = rd_val;
            end
            default: begin
            end
        endcase

        res.transfer_status = n.outcome;
        res.ready_res       = n.idle_flag | n.repeat_pending;
    end

    assign o_state  = n;
    assign o_result = res;
    assign o_wr     = wr;
endmodule

### hw/rtl/i2cms_checker.sv
// port-level checker for the i2c master status sequencer and its bind
`include "i2c_master_status_sequencer_defines.svh"

module i2cms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_cmd,
    input logic [1:0] i_out_status,
    input logic [7:0] i_out_tx_byte
);
    import i2cms_pkg::*;

    // a stalled result holds
    `I2CMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_tx_byte) && $stable(i_out_cmd), "stalled result changed")

    // an accepted item reaches the output once the result side is free
    `I2CMS_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 (!i_out_valid || i_out_ready), i_out_valid, "accepted item produced no result")

    // only one item waits behind a stalled result
    `I2CMS_ASSERT_NEXT(a_backpressure, i_clk, i_rst_n, i_out_valid && !i_out_ready && i_in_valid && i_in_ready, i_out_ready || !i_in_ready, "input taken with both stages full")

    // a start command only ever follows an accepted action, so never idle
    `I2CMS_ASSERT(a_start_active, i_clk, i_rst_n, i_out_valid && (i_out_cmd == CMD_START), i_out_status != OUT_IDLE, "start command with idle outcome")
endmodule

bind i2c_master_status_sequencer i2cms_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_cmd     (o_res.bus_command),
    .i_out_status  (o_res.transfer_status),
    .i_out_tx_byte (o_res.tx_byte)
);
